// File: rtl/core/dpmg_pkg.sv
// Shared types and constants for the drum pattern map generator.
// Holds the transfer structs, opcode and register index codes, and the sequencer states.
`default_nettype none

package dpmg_pkg;

    localparam int OUT_PARTS      = 3;
    localparam int NODES_PER_SIDE = 5;

    localparam logic [7:0] LEVEL_MAX    = 8'd255;
    localparam logic [7:0] ACCENT_LEVEL = 8'd192;

    typedef enum logic [1:0] {
        OP_EVAL   = 2'd0,
        OP_CYCLE  = 2'd1,
        OP_RESEED = 2'd2,
        OP_WRITE  = 2'd3
    } opcode_t;

    localparam logic [2:0] REG_MAP_X         = 3'd0;
    localparam logic [2:0] REG_MAP_Y         = 3'd1;
    localparam logic [2:0] REG_CHAOS         = 3'd2;
    localparam logic [2:0] REG_DENSITY_KICK  = 3'd3;
    localparam logic [2:0] REG_DENSITY_SNARE = 3'd4;
    localparam logic [2:0] REG_DENSITY_HAT   = 3'd5;
    localparam logic [2:0] REG_SEED          = 3'd6;

    typedef struct packed {
        opcode_t     opcode;
        logic [7:0]  step;
        logic [11:0] table_address;
        logic [7:0]  table_data;
    } in_item_t;

    typedef struct packed {
        logic [2:0] trigger_mask;
        logic [2:0] accent_mask;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRIME,
        ST_MAC,
        ST_FINISH,
        ST_RNG
    } seq_state_t;

endpackage

`default_nettype wire

// File: rtl/core/drum_pattern_map_generator.sv
// Evaluate: a prime state, then 7 passes per part through the single 8x8 multiply-accumulate,
// then a finish state that waits for a free output register. New-cycle items run one xorshift
// round per cycle; reseed and table writes complete as they are taken. Items are taken only in idle.
// Reset (rst_n, asynchronous, active low) clears control registers, generator word to one and
// the perturbation bytes; the pattern memory is not cleared and must be written before it is read.
// A finished result waits in the output register while the next item is taken.
`default_nettype none

module drum_pattern_map_generator
    import dpmg_pkg::*;
#(
    parameter int PARTS = 3,
    parameter int STEPS = 32
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire in_item_t   in_data,
    output logic            out_valid,
    input  wire logic       out_ready,
    output out_item_t       out_data,
    input  wire logic       cfg_write,
    input  wire logic [2:0] cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int PS         = PARTS * STEPS;
    localparam int DEPTH      = NODES_PER_SIDE * NODES_PER_SIDE * PS;
    localparam int AW         = $clog2(DEPTH);
    localparam int SW         = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int EVAL_PARTS = (PARTS < OUT_PARTS) ? PARTS : OUT_PARTS;
    localparam logic [16:0] STEP_RECIP = 17'((65536 + STEPS - 1) / STEPS);
    localparam logic [13:0] STEP_COUNT = 14'(STEPS);
    localparam logic [1:0]  LAST_PART  = 2'(EVAL_PARTS - 1);
    localparam logic [1:0]  LAST_RNG   = 2'(OUT_PARTS - 1);

    // reciprocal multiply gives the exact quotient for any 8-bit step
    function automatic logic [SW-1:0] step_wrap(input logic [7:0] s);
        logic [24:0] scaled;
        logic [13:0] whole;
        logic [7:0]  rem;
        scaled = 25'(s) * 25'(STEP_RECIP);
        whole  = 14'(scaled[23:16]) * STEP_COUNT;
        rem    = s - whole[7:0];
        return rem[SW-1:0];
    endfunction

    function automatic logic [31:0] xorshift(input logic [31:0] v);
        logic [31:0] t;
        t = v ^ (v << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return t;
    endfunction

    seq_state_t  state_reg, state_next;
    logic [1:0]  part_reg, part_next;
    logic [2:0]  op_reg, op_next;
    logic [SW-1:0] step_reg, step_next;
    logic [15:0] acc_reg, acc_next;
    logic [7:0]  top_reg, top_next;
    logic [7:0]  lvl_reg, lvl_next;
    logic [2:0]  trig_reg, trig_next;
    logic [2:0]  accm_reg, accm_next;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_data_reg, out_data_next;
    logic [31:0] rng_reg, rng_next;
    logic [7:0]  perturb_reg [OUT_PARTS];
    logic [7:0]  perturb_next [OUT_PARTS];

    logic [7:0]  map_x_reg, map_y_reg, chaos_reg;
    logic [7:0]  density_reg [OUT_PARTS];
    logic [15:0] seed_reg;

    logic [7:0]  mem [DEPTH];
    logic [7:0]  rd_data_reg;
    logic [AW-1:0] rd_addr, wr_addr;
    logic        wr_en;

    logic        accept;
    logic [1:0]  rd_slot, rd_part;
    logic [2:0]  rd_nx, rd_ny;
    logic [7:0]  wx, wy, wx_inv, wy_inv;
    logic [7:0]  mul_a, mul_b;
    logic [15:0] product, acc_base;
    logic        mac_clear, mac_en;

    logic        decide_en;
    logic [1:0]  decide_part;
    logic [8:0]  level_sum;
    logic [7:0]  level_sat;
    logic        fire, accent;
    logic        out_free;

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign wx     = {map_x_reg[5:0], 2'b00};
    assign wy     = {map_y_reg[5:0], 2'b00};
    assign wx_inv = LEVEL_MAX - wx;
    assign wy_inv = LEVEL_MAX - wy;

    // node slots: 0 (i,j), 1 (i+1,j), 2 (i,j+1), 3 (i+1,j+1)
    assign rd_nx   = {1'b0, map_x_reg[7:6]} + {2'b00, rd_slot[0]};
    assign rd_ny   = {1'b0, map_y_reg[7:6]} + {2'b00, rd_slot[1]};
    assign rd_addr = AW'((int'(rd_nx) * NODES_PER_SIDE + int'(rd_ny)) * PS
                         + int'(rd_part) * STEPS + int'(step_reg));

    assign wr_en   = accept && (in_data.opcode == OP_WRITE) && (int'(in_data.table_address) < DEPTH);
    assign wr_addr = AW'(in_data.table_address);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= in_data.table_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign product   = 16'(mul_a) * 16'(mul_b);
    assign acc_base  = mac_clear ? 16'd0 : acc_reg;

    // saturate level plus perturbation and compare
    assign level_sum = {1'b0, lvl_reg} + {1'b0, acc_reg[15:8]};
    assign level_sat = level_sum[8] ? LEVEL_MAX : level_sum[7:0];
    assign fire      = level_sat > (LEVEL_MAX - density_reg[decide_part]);
    assign accent    = level_sat > ACCENT_LEVEL;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.opcode == OP_EVAL)
                    begin
                        state_next = ST_PRIME;
                    end
                    else if (in_data.opcode == OP_CYCLE)
                    begin
                        state_next = ST_RNG;
                    end
                end
            end
            ST_PRIME:  state_next = ST_MAC;
            ST_MAC:
            begin
                if (op_reg == 3'd6 && part_reg == LAST_PART)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RNG:
            begin
                if (part_reg == LAST_RNG)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs and datapath
    always_comb
    begin
        in_ready       = (state_reg == ST_IDLE);
        part_next      = part_reg;
        op_next        = op_reg;
        step_next      = step_reg;
        top_next       = top_reg;
        lvl_next       = lvl_reg;
        trig_next      = trig_reg;
        accm_next      = accm_reg;
        rng_next       = rng_reg;
        perturb_next   = perturb_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        rd_slot        = 2'd0;
        rd_part        = part_reg;
        mul_a          = rd_data_reg;
        mul_b          = wx_inv;
        mac_clear      = 1'b1;
        mac_en         = 1'b0;
        decide_en      = 1'b0;
        decide_part    = part_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_data.opcode)
                        OP_EVAL:
                        begin
                            step_next = step_wrap(in_data.step);
                            part_next = 2'd0;
                            op_next   = 3'd0;
                            trig_next = 3'd0;
                            accm_next = 3'd0;
                        end
                        OP_CYCLE:
                        begin
                            part_next = 2'd0;
                        end
                        OP_RESEED:
                        begin
                            rng_next = {16'd0, seed_reg} + 32'd1;
                            for (int p = 0; p < OUT_PARTS; p++)
                            begin
                                perturb_next[p] = 8'd0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_PRIME:
            begin
                rd_slot = 2'd0;
            end
            ST_MAC:
            begin
                mac_en  = 1'b1;
                op_next = op_reg + 3'd1;
                // close out the previous part while its perturbation product sits in acc
                if (op_reg == 3'd0 && part_reg != 2'd0)
                begin
                    decide_en   = 1'b1;
                    decide_part = part_reg - 2'd1;
                end
                if (op_reg < 3'd3)
                begin
                    rd_slot = op_reg[1:0] + 2'd1;
                end
                else if (op_reg == 3'd6 && part_reg != LAST_PART)
                begin
                    rd_part = part_reg + 2'd1;
                end
                case (op_reg)
                    3'd0:
                    begin
                        mul_b = wx_inv;
                    end
                    3'd1:
                    begin
                        mul_b     = wx;
                        mac_clear = 1'b0;
                    end
                    3'd2:
                    begin
                        mul_b    = wx_inv;
                        top_next = acc_reg[15:8];
                    end
                    3'd3:
                    begin
                        mul_b     = wx;
                        mac_clear = 1'b0;
                    end
                    3'd4:
                    begin
                        mul_a = acc_reg[15:8];
                        mul_b = wy;
                    end
                    3'd5:
                    begin
                        mul_a     = top_reg;
                        mul_b     = wy_inv;
                        mac_clear = 1'b0;
                    end
                    default:
                    begin
                        mul_a    = perturb_reg[part_reg];
                        mul_b    = {2'b00, chaos_reg[7:2]};
                        lvl_next = acc_reg[15:8];
                        op_next  = 3'd0;
                        if (part_reg != LAST_PART)
                        begin
                            part_next = part_reg + 2'd1;
                        end
                    end
                endcase
            end
            ST_FINISH:
            begin
                decide_en   = out_free;
                decide_part = part_reg;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next.trigger_mask = trig_reg | (3'(fire) << decide_part);
                    out_data_next.accent_mask  = accm_reg | (3'(accent) << decide_part);
                end
            end
            ST_RNG:
            begin
                rng_next  = xorshift(rng_reg);
                part_next = part_reg + 2'd1;
                for (int p = 0; p < OUT_PARTS; p++)
                begin
                    if (part_reg == 2'(p))
                    begin
                        perturb_next[p] = rng_next[31:24];
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (decide_en)
        begin
            trig_next = trig_reg | (3'(fire) << decide_part);
            accm_next = accm_reg | (3'(accent) << decide_part);
        end
        acc_next = mac_en ? (acc_base + product) : acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            part_reg      <= 2'd0;
            op_reg        <= 3'd0;
            trig_reg      <= 3'd0;
            accm_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
            rng_reg       <= 32'd1;
            map_x_reg     <= 8'd0;
            map_y_reg     <= 8'd0;
            chaos_reg     <= 8'd0;
            seed_reg      <= 16'd0;
            for (int p = 0; p < OUT_PARTS; p++)
            begin
                perturb_reg[p] <= 8'd0;
                density_reg[p] <= 8'd0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            part_reg      <= part_next;
            op_reg        <= op_next;
            trig_reg      <= trig_next;
            accm_reg      <= accm_next;
            out_valid_reg <= out_valid_next;
            rng_reg       <= rng_next;
            perturb_reg   <= perturb_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_MAP_X:         map_x_reg      <= cfg_data[7:0];
                    REG_MAP_Y:         map_y_reg      <= cfg_data[7:0];
                    REG_CHAOS:         chaos_reg      <= cfg_data[7:0];
                    REG_DENSITY_KICK:  density_reg[0] <= cfg_data[7:0];
                    REG_DENSITY_SNARE: density_reg[1] <= cfg_data[7:0];
                    REG_DENSITY_HAT:   density_reg[2] <= cfg_data[7:0];
                    REG_SEED:          seed_reg       <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        step_reg     <= step_next;
        acc_reg      <= acc_next;
        top_reg      <= top_next;
        lvl_reg      <= lvl_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// File: sim/drum_pattern_map_generator_test.sv
// Self-checking bench for drum_pattern_map_generator: loads the pattern map at the evaluated
// steps, runs directed and random step, cycle, reseed and table-write transfers under random
// back-pressure. Depends on dpmg_pkg and the drum_pattern_map_generator RTL only.
`timescale 1ns / 100ps

module drum_pattern_map_generator_test;
    import dpmg_pkg::*;

    localparam int PARTS        = 3;
    localparam int STEPS        = 32;
    localparam int STORE_DEPTH  = NODES_PER_SIDE * NODES_PER_SIDE * PARTS * STEPS;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE       = 30;
    localparam int PHASE_ITEMS  = 70;
    localparam int LOADED_STEPS = 4;

    // no register lives at this index; writes to it must be dropped
    localparam logic [2:0] REG_UNUSED = 3'd7;

    // Mirrors the generator: registers, xorshift word, perturbations and the level map.
    class trigger_board;
        logic [7:0]  map_x, map_y, chaos;
        logic [15:0] seed;
        logic [7:0]  density [OUT_PARTS];
        logic [31:0] rng_word;
        logic [7:0]  perturb [OUT_PARTS];
        logic [7:0]  levels [STORE_DEPTH];
        out_item_t   masks_due [$];
        int          errors, results_seen, evals, cycles, reseeds, writes;

        function new();
            map_x = '0;
            map_y = '0;
            chaos = '0;
            seed  = '0;
            rng_word = 32'd1;
            for (int p = 0; p < OUT_PARTS; p++)
            begin
                density[p] = '0;
                perturb[p] = '0;
            end
            errors = 0;
            results_seen = 0;
            evals = 0;
            cycles = 0;
            reseeds = 0;
            writes = 0;
        endfunction

        function void write_reg(logic [2:0] index, logic [15:0] value);
            case (index)
                REG_MAP_X:         map_x = value[7:0];
                REG_MAP_Y:         map_y = value[7:0];
                REG_CHAOS:         chaos = value[7:0];
                REG_DENSITY_KICK:  density[0] = value[7:0];
                REG_DENSITY_SNARE: density[1] = value[7:0];
                REG_DENSITY_HAT:   density[2] = value[7:0];
                REG_SEED:          seed = value;
                default: ;
            endcase
        endfunction

        function int unsigned mix(int unsigned a, int unsigned b, int unsigned w);
            return (a * (255 - w) + b * w) >> 8;
        endfunction

        function int unsigned node_level(int unsigned nx, int unsigned ny, int unsigned off);
            return levels[(nx * NODES_PER_SIDE + ny) * PARTS * STEPS + off];
        endfunction

        function out_item_t masks_for_step(logic [7:0] step);
            out_item_t   r;
            int unsigned col, row, wx, wy, off, top, bot, pert, val;
            col = map_x[7:6];
            row = map_y[7:6];
            wx  = {map_x[5:0], 2'b00};
            wy  = {map_y[5:0], 2'b00};
            r   = '0;
            for (int p = 0; p < OUT_PARTS && p < PARTS; p++)
            begin
                off  = p * STEPS + step % STEPS;
                top  = mix(node_level(col, row, off), node_level(col + 1, row, off), wx);
                bot  = mix(node_level(col, row + 1, off),
                           node_level(col + 1, row + 1, off), wx);
                pert = (int'(perturb[p]) * int'(chaos >> 2)) >> 8;
                val  = mix(top, bot, wy) + pert;
                if (val > LEVEL_MAX)
                    val = LEVEL_MAX;
                if (val > LEVEL_MAX - density[p])
                    r.trigger_mask[p] = 1'b1;
                if (val > ACCENT_LEVEL)
                    r.accent_mask[p] = 1'b1;
            end
            return r;
        endfunction

        function void take_item(in_item_t item);
            case (item.opcode)
                OP_CYCLE:
                begin
                    cycles++;
                    for (int p = 0; p < OUT_PARTS; p++)
                    begin
                        rng_word ^= rng_word << 13;
                        rng_word ^= rng_word >> 17;
                        rng_word ^= rng_word << 5;
                        perturb[p] = rng_word[31:24];
                    end
                end
                OP_RESEED:
                begin
                    reseeds++;
                    rng_word = {16'd0, seed} + 32'd1;
                    for (int p = 0; p < OUT_PARTS; p++)
                        perturb[p] = '0;
                end
                OP_WRITE:
                begin
                    writes++;
                    // out-of-range addresses leave the map untouched
                    if (item.table_address < STORE_DEPTH)
                        levels[item.table_address] = item.table_data;
                end
                default:
                begin
                    evals++;
                    masks_due.push_back(masks_for_step(item.step));
                end
            endcase
        endfunction

        function void check_masks(out_item_t got);
            out_item_t want;
            results_seen++;
            if (masks_due.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing outstanding: trigger %b accent %b",
                         $time, got.trigger_mask, got.accent_mask);
                return;
            end
            want = masks_due.pop_front();
            if (got.trigger_mask !== want.trigger_mask)
            begin
                errors++;
                $display("%0t: trigger_mask expected %b got %b",
                         $time, want.trigger_mask, got.trigger_mask);
            end
            if (got.accent_mask !== want.accent_mask)
            begin
                errors++;
                $display("%0t: accent_mask expected %b got %b",
                         $time, want.accent_mask, got.accent_mask);
            end
        endfunction

        function int pending();
            return masks_due.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_data;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    trigger_board board;
    int           cycle_count = 0;
    int           settings_applied = 0;
    int           hold_request = 0;
    bit           sender_quiet = 1'b0;
    bit           receiver_quiet = 1'b0;

    drum_pattern_map_generator #(
        .PARTS (PARTS),
        .STEPS (STEPS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // note every transfer on either side
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (in_valid && in_ready)
                board.take_item(in_data);
            if (out_valid && out_ready)
                board.check_masks(out_data);
        end
    end

    // result side: random stalls, plus long hold-offs on request
    initial
    begin : result_sink
        int stall_left;
        int roll;
        stall_left = 0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                stall_left = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!receiver_quiet)
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 12)
                        stall_left = $urandom_range(1, 3);
                    else if (roll < 14)
                        stall_left = $urandom_range(10, 40);
                end
            end
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (sender_quiet || roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] pick_byte();
        int roll;
        roll = $urandom_range(0, 3);
        if (roll == 0)
            return 8'h00;
        if (roll == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // evaluated steps are kept to a few positions in the pattern, so only those get loaded
    function automatic int unsigned loaded_step(int unsigned k);
        case (k)
            0:       return 0;
            1:       return 5;
            2:       return 17;
            default: return STEPS - 1;
        endcase
    endfunction

    // a loaded position, lifted by a random whole number of patterns
    function automatic int unsigned pick_step();
        return loaded_step($urandom_range(0, LOADED_STEPS - 1))
               + STEPS * $urandom_range(0, 256 / STEPS - 1);
    endfunction

    function automatic in_item_t make_item(opcode_t op, int unsigned step,
                                           int unsigned addr, int unsigned data);
        in_item_t item;
        item.opcode        = op;
        item.step          = step[7:0];
        item.table_address = addr[11:0];
        item.table_data    = data[7:0];
        return item;
    endfunction

    function automatic in_item_t random_item();
        in_item_t item;
        int       roll;
        roll = $urandom_range(0, 99);
        item = make_item(OP_EVAL, pick_step(), $urandom_range(0, STORE_DEPTH - 1),
                         $urandom_range(0, 255));
        if (roll < 50)
            item.opcode = OP_EVAL;
        else if (roll < 62)
            item.opcode = OP_CYCLE;
        else if (roll < 68)
            item.opcode = OP_RESEED;
        else
        begin
            item.opcode = OP_WRITE;
            if ($urandom_range(0, 9) == 0)
                item.table_address = 12'($urandom_range(STORE_DEPTH, 4095));
        end
        return item;
    endfunction

    // entered and left at a falling edge; valid holds until the transfer
    task automatic send_item(input in_item_t item);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data  <= item;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_op(opcode_t op, int unsigned step, int unsigned addr,
                           int unsigned data);
        send_item(make_item(op, step, addr, data));
    endtask

    // drop valid, wait out every result, then let trailing cycle work finish
    task automatic idle_until_drained();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic put_reg(logic [2:0] index, logic [15:0] value);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        board.write_reg(index, value);
        @(negedge clk);
    endtask

    task automatic apply_settings(logic [7:0] x, logic [7:0] y, logic [7:0] ch,
                                  logic [7:0] dk, logic [7:0] ds, logic [7:0] dh,
                                  logic [15:0] sd);
        put_reg(REG_MAP_X, {8'h00, x});
        put_reg(REG_MAP_Y, {8'h00, y});
        put_reg(REG_CHAOS, {8'h00, ch});
        put_reg(REG_DENSITY_KICK, {8'h00, dk});
        put_reg(REG_DENSITY_SNARE, {8'h00, ds});
        put_reg(REG_DENSITY_HAT, {8'h00, dh});
        put_reg(REG_SEED, sd);
        put_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
        cfg_write <= 1'b0;
        settings_applied++;
    endtask

    initial
    begin : stimulus
        in_item_t item;
        int       sent;
        logic [15:0] sd;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        board = new();
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // load every node and part at the steps that get evaluated
        for (int node = 0; node < NODES_PER_SIDE * NODES_PER_SIDE; node++)
        begin
            for (int part = 0; part < PARTS; part++)
            begin
                for (int k = 0; k < LOADED_STEPS; k++)
                begin
                    send_op(OP_WRITE, 0, (node * PARTS + part) * STEPS + loaded_step(k),
                            $urandom_range(0, 255));
                end
            end
        end
        idle_until_drained();

        // corner of the map, no chaos
        apply_settings(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 16'h0000);
        send_op(OP_WRITE, 0, 0, 255);
        send_op(OP_WRITE, 0, STEPS, 0);
        send_op(OP_WRITE, 0, 2 * STEPS, 193);
        send_op(OP_EVAL, 0, 0, 0);
        send_op(OP_EVAL, STEPS, 0, 0);
        send_op(OP_EVAL, 255, 0, 0);
        send_op(OP_WRITE, 0, STORE_DEPTH - 1, 255);
        send_op(OP_WRITE, 0, STORE_DEPTH, 0);
        send_op(OP_WRITE, 255, 4095, 8'hAA);
        send_op(OP_CYCLE, 0, 0, 0);
        send_op(OP_EVAL, 0, 0, 0);
        send_op(OP_RESEED, 0, 0, 0);
        send_op(OP_EVAL, 0, 0, 0);
        idle_until_drained();

        // far corner, full chaos, widest seed
        apply_settings(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h80, 8'hFF, 16'hFFFF);
        send_op(OP_RESEED, 0, 0, 0);
        send_op(OP_CYCLE, 0, 0, 0);
        send_op(OP_EVAL, STEPS - 1, 0, 0);
        send_op(OP_EVAL, 128, 0, 0);
        send_op(OP_CYCLE, 0, 0, 0);
        send_op(OP_CYCLE, 0, 0, 0);
        send_op(OP_EVAL, 255, 0, 0);
        send_op(OP_RESEED, 0, 0, 0);
        send_op(OP_EVAL, STEPS - 1, 0, 0);

        for (int phase = 0; phase < 6; phase++)
        begin
            idle_until_drained();
            sd = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535));
            apply_settings(pick_byte(), pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                           pick_byte(), sd);
            sender_quiet = (phase == 2);
            receiver_quiet = (phase == 2);
            if (phase == 3)
            begin
                // hold the result side long enough that the input backs up
                hold_request = 300;
                sender_quiet = 1'b1;
                repeat (16)
                    send_op(OP_EVAL, pick_step(), 0, 0);
                sender_quiet = 1'b0;
                idle_until_drained();
            end
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                item = random_item();
                send_item(item);
                if (!(item.opcode == OP_WRITE && item.table_address >= STORE_DEPTH))
                    sent++;
            end
        end
        idle_until_drained();

        $display("Covered %0d evaluate, %0d cycle, %0d reseed and %0d table-write transfers",
                 board.evals, board.cycles, board.reseeds, board.writes);
        $display("across %0d register settings; %0d results compared, %0d mismatches",
                 settings_applied, board.results_seen, board.errors);
        if (board.errors == 0 && board.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: files.f
rtl/core/dpmg_pkg.sv
rtl/core/drum_pattern_map_generator.sv
sim/drum_pattern_map_generator_test.sv
